/* hdl/counting_semaphore_table_core_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the counting semaphore table core.
// Each macro expands to one labelled concurrent assertion on the rising clock
// edge, switched off while reset is high.
// ----------------------------------------------------------------------------
`ifndef COUNTING_SEMAPHORE_TABLE_CORE_DEFINES_SVH
`define COUNTING_SEMAPHORE_TABLE_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CST_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CST_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/cst_pkg.sv */
// ----------------------------------------------------------------------------
// cst_pkg
// Types, sizes and codes shared by the counting semaphore table core.
// ----------------------------------------------------------------------------
`default_nettype none

package cst_pkg;

   // Table geometry.
   localparam int NUM_SLOTS  = 16;
   localparam int COUNT_BITS = 16;
   localparam int SLOT_BITS  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

   typedef logic [SLOT_BITS-1:0]  slot_idx_type;
   typedef logic [COUNT_BITS-1:0] count_type;

   localparam count_type COUNT_MAX = '1;

   // Request kinds carried on the request sideband.
   typedef enum logic [1:0] {
      REQ_CREATE  = 2'd0,
      REQ_DESTROY = 2'd1,
      REQ_WAIT    = 2'd2,
      REQ_SIGNAL  = 2'd3
   } req_kind_type;

   // Result status codes.
   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_INVALID  = 3'd1,
      ST_FULL     = 3'd2,
      ST_BLOCK    = 3'd3,
      ST_OVERFLOW = 3'd4
   } status_type;

   // Access to the slot store for one operation.
   typedef struct packed {
      logic         rd_en;
      slot_idx_type rd_addr;
      logic         wr_en;
      slot_idx_type wr_addr;
      count_type    wr_data;
      logic         used_set;
      logic         used_clr;
   } store_cmd_type;

   // What the slot store reports back.
   typedef struct packed {
      count_type              rd_count;
      logic [NUM_SLOTS-1:0]   used;
      logic                   full;
      slot_idx_type           free_idx;
   } store_stat_type;

   // Loaded count: the initial value, saturated at the largest count.
   function automatic count_type sat_init(input logic [15:0] init);
      logic [31:0] wide;
      wide = 32'(init);
      if (wide > 32'(COUNT_MAX)) begin
         return COUNT_MAX;
      end
      return COUNT_BITS'(wide);
   endfunction

   // Low sixteen bits of a count for the result.
   function automatic logic [15:0] count_low(input count_type c);
      logic [31:0] wide;
      wide = 32'(c);
      return wide[15:0];
   endfunction

   // Low four bits of a slot number for the result.
   function automatic logic [3:0] slot_low(input slot_idx_type s);
      logic [31:0] wide;
      wide = 32'(s);
      return wide[3:0];
   endfunction

endpackage

`default_nettype wire

/* hdl/cst_slot_store.sv */
// ----------------------------------------------------------------------------
// cst_slot_store
// Holds the semaphore table: a used mark per slot in flip-flops that reset
// clears, and the counts in a synchronous memory with a registered read.
// Also finds the lowest free slot.
// ----------------------------------------------------------------------------
`default_nettype none

module cst_slot_store (
   input  wire                     clock,
   input  wire                     reset,
   input  cst_pkg::store_cmd_type  cmd,
   output cst_pkg::store_stat_type stat
);
   import cst_pkg::*;

   logic [NUM_SLOTS-1:0] used_ff;
   count_type            count_mem [NUM_SLOTS];
   count_type            rd_data_ff;
   logic                 full;
   slot_idx_type         free_idx;

   // Used marks: reset frees every slot.
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else begin
         if (cmd.used_set) begin
            used_ff[cmd.wr_addr] <= 1'b1;
         end
         if (cmd.used_clr) begin
            used_ff[cmd.wr_addr] <= 1'b0;
         end
      end
   end

   // Count memory. An entry's read value is only used while its slot is in use, and every
   // create writes the entry first, so the memory needs no clearing.
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         count_mem[cmd.wr_addr] <= cmd.wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= count_mem[cmd.rd_addr];
      end
   end

   // Lowest free slot, searched from the top so the lowest index wins.
   always_comb begin
      full     = 1'b1;
      free_idx = '0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            full     = 1'b0;
            free_idx = SLOT_BITS'(i);
         end
      end
   end

   assign stat.rd_count = rd_data_ff;
   assign stat.used     = used_ff;
   assign stat.full     = full;
   assign stat.free_idx = free_idx;

endmodule

`default_nettype wire

/* hdl/counting_semaphore_table_core.sv */
// ----------------------------------------------------------------------------
// counting_semaphore_table_core
// Sequence: the count memory is read in the accept cycle; the modify and write
// back follow in the execute step, which waits while the result register is
// full and not taken, and loads the result register. A new request is not
// accepted until the last one has been written back.
// Reset: synchronous; frees every slot at once, with no clearing pass.
// Description: table of counting semaphores with create, destroy, wait and
// signal requests, one result per request.
// ----------------------------------------------------------------------------
`default_nettype none
`include "counting_semaphore_table_core_defines.svh"

module counting_semaphore_table_core (
   input  wire         clock,
   input  wire         reset,
   // Request channel
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [23:0] req_tdata,  // sem_id [7:0], start_count [23:8]
   input  wire  [1:0]  req_tuser,  // req_type [1:0]
   // Result channel
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [23:0] rsp_tdata   // status [2:0], alloc_id [6:3], wake [7],
                                   // count_after [23:8]
);
   import cst_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   state_type      state_ff, state_in;
   req_kind_type   kind_ff;
   slot_idx_type   slot_ff;
   logic           in_range_ff;
   logic [15:0]    init_ff;

   logic           rsp_valid_ff, rsp_valid_in;
   status_type     rsp_status_ff, rsp_status_in;
   logic [3:0]     rsp_alloc_ff, rsp_alloc_in;
   logic           rsp_wake_ff, rsp_wake_in;
   logic [15:0]    rsp_count_ff, rsp_count_in;

   store_cmd_type  cmd;
   store_stat_type stat;

   logic           req_fire;
   logic           exec_fire;
   logic           id_ok;
   logic           in_range;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign exec_fire  = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_tready);
   assign in_range   = ({1'b0, req_tdata[7:0]} < 9'(NUM_SLOTS));
   assign id_ok      = in_range_ff && stat.used[slot_ff];

   // Sequencer: read in the accept cycle, modify and write back in the execute step.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (exec_fire) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Request fields captured on transfer.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         kind_ff     <= req_kind_type'(req_tuser);
         slot_ff     <= req_tdata[SLOT_BITS-1:0];
         in_range_ff <= in_range;
         init_ff     <= req_tdata[23:8];
      end
   end

   // Operation: decide the result and the write back.
   always_comb begin
      cmd.rd_en     = req_fire && in_range;
      cmd.rd_addr   = req_tdata[SLOT_BITS-1:0];
      cmd.wr_en     = 1'b0;
      cmd.wr_addr   = slot_ff;
      cmd.wr_data   = '0;
      cmd.used_set  = 1'b0;
      cmd.used_clr  = 1'b0;
      rsp_status_in = ST_OK;
      rsp_alloc_in  = '0;
      rsp_wake_in   = 1'b0;
      rsp_count_in  = '0;
      unique case (kind_ff)
         REQ_CREATE: begin
            if (stat.full) begin
               rsp_status_in = ST_FULL;
            end else begin
               cmd.wr_en    = 1'b1;
               cmd.wr_addr  = stat.free_idx;
               cmd.wr_data  = sat_init(init_ff);
               cmd.used_set = 1'b1;
               rsp_alloc_in = slot_low(stat.free_idx);
               rsp_count_in = count_low(sat_init(init_ff));
            end
         end
         REQ_DESTROY: begin
            if (!id_ok) begin
               rsp_status_in = ST_INVALID;
            end else begin
               cmd.wr_en    = 1'b1;
               cmd.used_clr = 1'b1;
               rsp_wake_in  = 1'b1;
            end
         end
         REQ_WAIT: begin
            if (!id_ok) begin
               rsp_status_in = ST_INVALID;
            end else if (stat.rd_count == '0) begin
               rsp_status_in = ST_BLOCK;
            end else begin
               cmd.wr_en    = 1'b1;
               cmd.wr_data  = stat.rd_count - count_type'(1);
               rsp_count_in = count_low(stat.rd_count - count_type'(1));
            end
         end
         REQ_SIGNAL: begin
            if (!id_ok) begin
               rsp_status_in = ST_INVALID;
            end else if (stat.rd_count == COUNT_MAX) begin
               rsp_status_in = ST_OVERFLOW;
               rsp_count_in  = count_low(stat.rd_count);
            end else begin
               cmd.wr_en    = 1'b1;
               cmd.wr_data  = stat.rd_count + count_type'(1);
               rsp_wake_in  = 1'b1;
               rsp_count_in = count_low(stat.rd_count + count_type'(1));
            end
         end
         default: begin
            rsp_status_in = ST_INVALID;
         end
      endcase
      // Only commit when the result register can take the outcome.
      if (!exec_fire) begin
         cmd.wr_en    = 1'b0;
         cmd.used_set = 1'b0;
         cmd.used_clr = 1'b0;
      end
   end

   cst_slot_store u_store (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .stat  (stat)
   );

   // Result register: loaded on the write-back cycle, emptied on transfer.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (exec_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (exec_fire) begin
         rsp_status_ff <= rsp_status_in;
         rsp_alloc_ff  <= rsp_alloc_in;
         rsp_wake_ff   <= rsp_wake_in;
         rsp_count_ff  <= rsp_count_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_count_ff, rsp_wake_ff, rsp_alloc_ff, rsp_status_ff};

   // Checks on the sequencer and the result register.
   `CST_ASSERT_NEXT(a_accept_to_exec, clock, reset, req_fire, state_ff == S_EXEC,
      "accepted request did not move to the execute step")
   `CST_ASSERT_NEXT(a_exec_loads_result, clock, reset, exec_fire, rsp_valid_ff,
      "write-back cycle did not load the result register")
   `CST_ASSERT_SAME(a_write_only_in_exec, clock, reset,
      cmd.wr_en || cmd.used_set || cmd.used_clr, exec_fire,
      "table written outside a committed write-back cycle")
   `CST_ASSERT_SAME(a_wake_means_ok, clock, reset, rsp_valid_ff && rsp_wake_ff,
      rsp_status_ff == ST_OK, "wake raised on a failed request")
   `CST_ASSERT_SAME(a_alloc_means_ok, clock, reset,
      rsp_valid_ff && (rsp_alloc_ff != 4'd0), rsp_status_ff == ST_OK,
      "slot number reported on a failed request")

endmodule

`default_nettype wire
